// ----- hdl/necc_pkg.sv -----
// Package for the NAND erased-page check: field widths, status bit positions,
// verdict codes and the zero-bit counting function. No dependencies.
`default_nettype none

package necc_pkg;

	localparam int STATUS_W   = 8;
	localparam int WORD_W     = 32;
	localparam int COUNT_W    = 6;
	localparam int ZCOUNT_W   = 7;
	localparam int VERDICT_W  = 2;
	localparam int POPCNT_W   = $clog2(WORD_W + 1);

	localparam int STATUS_FAIL_BIT = 7;

	localparam logic [COUNT_W-1:0] ECC_STRENGTH_RESET = 6'd32;

	typedef logic [VERDICT_W-1:0] verdict_t;

	localparam verdict_t VERDICT_CLEAN         = 2'd0;
	localparam verdict_t VERDICT_ERASED        = 2'd1;
	localparam verdict_t VERDICT_UNCORRECTABLE = 2'd2;

	function automatic logic [POPCNT_W-1:0] zeros_in_word(input logic [WORD_W-1:0] w);
		logic [POPCNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < WORD_W; i++) begin
			n = n + {{(POPCNT_W-1){1'b0}}, ~w[i]};
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/nand_ecc_erased_page_check.sv -----
// NAND erased-page check, top level. Uses necc_pkg for widths, verdict codes
// and the zero-bit counter.
// An input register and a result register bracket the count/compare logic.
//
// Takes one page data word per clock with its ECC status byte; the word marked
// last yields one verdict via the input and result registers; others yield
// nothing. Throughput is one word per clock, set by the combinational zero-bit
// count and accumulate between those registers; the input stalls only while a
// verdict waits in the result register and the staged word is also a last
// word. ecc_strength resets to 32; the user writes it through cfg_wr_en and
// cfg_wr_data only while no page is in flight, which the block does not enforce.
`default_nettype none

module nand_ecc_erased_page_check
	import necc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [COUNT_W-1:0]   cfg_wr_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [STATUS_W-1:0]  status_byte,
	input  wire logic [WORD_W-1:0]    data_word,
	input  wire logic                 last_word,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output verdict_t                  verdict,
	output logic [COUNT_W-1:0]        corrected_bits,
	output logic [ZCOUNT_W-1:0]       zero_bits
);

	logic [COUNT_W-1:0]  ecc_strength_q;
	logic [ZCOUNT_W-1:0] zero_count_q;

	logic                valid_s1;
	logic [STATUS_W-1:0] status_s1;
	logic [WORD_W-1:0]   word_s1;
	logic                last_s1;

	logic                out_valid_q;
	verdict_t            verdict_q;
	logic [COUNT_W-1:0]  corrected_q;
	logic [ZCOUNT_W-1:0] zero_bits_q;

	logic                advance;
	logic                in_accept;
	logic                failed;
	logic [COUNT_W-1:0]  err_count;
	logic [ZCOUNT_W-1:0] count_ext;
	logic [ZCOUNT_W-1:0] half_ext;
	logic [ZCOUNT_W-1:0] zero_sum;
	logic [ZCOUNT_W-1:0] zero_next;
	logic                bad;

	assign advance   = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	assign failed    = status_s1[STATUS_FAIL_BIT];
	assign err_count = status_s1[COUNT_W-1:0];
	assign count_ext = {{(ZCOUNT_W-COUNT_W){1'b0}}, err_count};
	assign half_ext  = {{(ZCOUNT_W-COUNT_W+1){1'b0}}, ecc_strength_q[COUNT_W-1:1]};
	assign zero_sum  = zero_count_q + {{(ZCOUNT_W-POPCNT_W){1'b0}}, zeros_in_word(word_s1)};
	// accumulate only on failed words; stop once the sum has passed this word's error count
	assign zero_next = (failed && zero_count_q <= count_ext) ? zero_sum : zero_count_q;
	assign bad       = (zero_next > count_ext) && (zero_next > half_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ecc_strength_q <= ECC_STRENGTH_RESET;
		end else if (cfg_wr_en) begin
			ecc_strength_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			status_s1 <= status_byte;
			word_s1   <= data_word;
			last_s1   <= last_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_count_q <= '0;
		end else if (advance) begin
			zero_count_q <= last_s1 ? '0 : zero_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			if (!failed) begin
				verdict_q   <= VERDICT_CLEAN;
				corrected_q <= err_count;
				zero_bits_q <= '0;
			end else begin
				verdict_q   <= bad ? VERDICT_UNCORRECTABLE : VERDICT_ERASED;
				corrected_q <= '0;
				zero_bits_q <= zero_next;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign verdict        = verdict_q;
	assign corrected_bits = corrected_q;
	assign zero_bits      = zero_bits_q;

	// sum can never pass 63 + 32
	a_zero_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		zero_count_q <= 7'd95)
		else $error("zero count out of range");

	// sum restarts after every last word
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (zero_count_q == '0))
		else $error("zero count not cleared after last word");

	// a waiting verdict is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !(advance && last_s1))
		else $error("verdict overwritten while stalled");

	a_clean_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && verdict_q == VERDICT_CLEAN) |-> (zero_bits_q == '0))
		else $error("clean verdict carries zero count");

	a_bad_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (verdict_q == VERDICT_ERASED || verdict_q == VERDICT_UNCORRECTABLE))
		|-> (corrected_q == '0))
		else $error("failed verdict carries corrected count");

endmodule

`default_nettype wire
